[hdl/job_scheduler_fcfs_sjf_rr_aging_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the job scheduler
// Clocked concurrent checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef JOB_SCHEDULER_FCFS_SJF_RR_AGING_UNIT_MACROS_SVH
`define JOB_SCHEDULER_FCFS_SJF_RR_AGING_UNIT_MACROS_SVH

// Condition holds at every clock edge.
`define JS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define JS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define JS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/jsched_pkg.sv]
// ----------------------------------------------------------------------------
// jsched_pkg
// Types, constants and helpers shared by the job scheduler files.
// ----------------------------------------------------------------------------
`default_nettype none

package jsched_pkg;

  localparam int MAX_JOBS  = 3;
  localparam int MAX_LINES = 256;

  localparam int JOB_W   = 2;                        // job id width
  localparam int LINE_W  = $clog2(MAX_LINES + 1);    // line counter width
  localparam int IDX_W   = 8;                        // line index output width
  localparam int FILL_W  = 2;                        // queue fill width
  localparam int Q_W     = 4;                        // quantum width
  localparam int CNT_W   = 2;                        // job count register width
  localparam int DATA_W  = 32;
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W = REG_IDX_W + 2;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_e;

  localparam logic [REG_IDX_W-1:0] REG_POLICY      = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_JOB_COUNT   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_FIRST_LINES = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SECOND_LINES = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_THIRD_LINES = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RR_QUANTUM  = REG_IDX_W'(5);

  typedef struct packed {
    policy_e                          policy;
    logic [CNT_W-1:0]                 job_count;
    logic [MAX_JOBS-1:0][LINE_W-1:0]  job_lines;
    logic [Q_W-1:0]                   rr_quantum;
  } cfg_t;

  typedef struct packed {
    logic [MAX_JOBS-1:0][JOB_W-1:0]   run_queue;
    logic [FILL_W-1:0]                queue_fill;
    logic [MAX_JOBS-1:0][LINE_W-1:0]  next_line;
    logic [MAX_JOBS-1:0][LINE_W-1:0]  aging_score;
    logic [Q_W-1:0]                   quantum_used;
  } sched_state_t;

  typedef struct packed {
    logic [JOB_W-1:0] job_id;
    logic [IDX_W-1:0] line_index;
    logic             all_done;
  } res_t;

  // Clamp a raw line count into 1..MAX_LINES.
  function automatic logic [LINE_W-1:0] job_len(input logic [LINE_W-1:0] raw);
    logic [LINE_W-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = LINE_W'(1);
    end else if (32'(raw) > MAX_LINES) begin
      v = LINE_W'(MAX_LINES);
    end
    return v;
  endfunction

  // Clamp the job count register into 1..MAX_JOBS.
  function automatic logic [FILL_W-1:0] batch_size(input logic [CNT_W-1:0] raw);
    logic [FILL_W-1:0] n;
    n = FILL_W'(raw);
    if (raw == '0) begin
      n = FILL_W'(1);
    end else if (32'(raw) > MAX_JOBS) begin
      n = FILL_W'(MAX_JOBS);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/jsched_if.sv]
// ----------------------------------------------------------------------------
// jsched interfaces
// Valid/ready channels for tick items in and schedule results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsched_in_if;
  import jsched_pkg::*;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface jsched_out_if;
  import jsched_pkg::*;

  logic             valid;
  logic             ready;
  logic [JOB_W-1:0] job_id;
  logic [IDX_W-1:0] line_index;
  logic             all_done;

  modport source (output valid, output job_id, output line_index, output all_done,
                  input ready);
  modport sink   (input valid, input job_id, input line_index, input all_done,
                  output ready);
endinterface

`default_nettype wire

[hdl/jsched_regs.sv]
// ----------------------------------------------------------------------------
// jsched_regs
// APB configuration registers of the job scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module jsched_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jsched_pkg::PADDR_W-1:0] paddr,
  input  logic [jsched_pkg::DATA_W-1:0]  pwdata,
  output logic [jsched_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output jsched_pkg::cfg_t              cfg_o
);
  import jsched_pkg::*;

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy     <= POL_FCFS;
      cfg_q.job_count  <= CNT_W'(1);
      for (int j = 0; j < MAX_JOBS; j++) begin
        cfg_q.job_lines[j] <= LINE_W'(1);
      end
      cfg_q.rr_quantum <= Q_W'(2);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POLICY:       cfg_q.policy       <= policy_e'(pwdata[1:0]);
        REG_JOB_COUNT:    cfg_q.job_count    <= pwdata[CNT_W-1:0];
        REG_FIRST_LINES:  cfg_q.job_lines[0] <= pwdata[LINE_W-1:0];
        REG_SECOND_LINES: cfg_q.job_lines[1] <= pwdata[LINE_W-1:0];
        REG_THIRD_LINES:  cfg_q.job_lines[2] <= pwdata[LINE_W-1:0];
        REG_RR_QUANTUM:   cfg_q.rr_quantum   <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLICY:       prdata = DATA_W'(cfg_q.policy);
      REG_JOB_COUNT:    prdata = DATA_W'(cfg_q.job_count);
      REG_FIRST_LINES:  prdata = DATA_W'(cfg_q.job_lines[0]);
      REG_SECOND_LINES: prdata = DATA_W'(cfg_q.job_lines[1]);
      REG_THIRD_LINES:  prdata = DATA_W'(cfg_q.job_lines[2]);
      REG_RR_QUANTUM:   prdata = DATA_W'(cfg_q.rr_quantum);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/jsched_step.sv]
// ----------------------------------------------------------------------------
// jsched_step
// One scheduling tick: reload, drop finished jobs, age, pick, rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module jsched_step (
  input  jsched_pkg::cfg_t         cfg_i,
  input  jsched_pkg::sched_state_t cur_i,
  input  logic                     restart_i,
  output jsched_pkg::sched_state_t nxt_o,
  output jsched_pkg::res_t         res_o
);
  import jsched_pkg::*;

  logic [MAX_JOBS-1:0][LINE_W-1:0] len;
  logic [FILL_W-1:0]               n_jobs;
  logic [MAX_JOBS-1:0][JOB_W-1:0]  rank;
  logic [MAX_JOBS-1:0][JOB_W-1:0]  ld_rq;
  logic [MAX_JOBS-1:0][LINE_W-1:0] ld_sc;

  logic [MAX_JOBS-1:0][JOB_W-1:0]  rq0, rq1, rq2, rq3;
  logic [FILL_W-1:0]               fill0, fill1;
  logic [MAX_JOBS-1:0][LINE_W-1:0] nl0, nl2;
  logic [MAX_JOBS-1:0][LINE_W-1:0] sc0, sc2;
  logic [Q_W-1:0]                  qu0, qu1, qu3, qsum, qlim;
  logic [(1<<JOB_W)-1:0]           fin_vec;
  logic [JOB_W-1:0]                head, cand_pos;
  logic [FILL_W-1:0]               keep_cnt, ord_cnt;
  logic                            found;

  // Batch load: clamped lengths, shortest-first ranks (ties to later arrival).
  always_comb begin
    n_jobs = batch_size(cfg_i.job_count);
    for (int j = 0; j < MAX_JOBS; j++) begin
      len[j]   = job_len(cfg_i.job_lines[j]);
    end
    for (int j = 0; j < MAX_JOBS; j++) begin
      rank[j]  = '0;
      ld_sc[j] = (FILL_W'(j) < n_jobs) ? len[j] : '0;
      for (int k = 0; k < MAX_JOBS; k++) begin
        if (k != j && FILL_W'(k) < n_jobs &&
            ((len[k] < len[j]) || (len[k] == len[j] && k > j))) begin
          rank[j] = rank[j] + JOB_W'(1);
        end
      end
    end
    for (int i = 0; i < MAX_JOBS; i++) begin
      ld_rq[i] = JOB_W'(i);
    end
    if (cfg_i.policy == POL_SJF || cfg_i.policy == POL_AGING) begin
      for (int j = 0; j < MAX_JOBS; j++) begin
        if (FILL_W'(j) < n_jobs) begin
          ld_rq[rank[j]] = JOB_W'(j);
        end
      end
    end
  end

  always_comb begin
    rq0   = restart_i ? ld_rq : cur_i.run_queue;
    fill0 = restart_i ? n_jobs : cur_i.queue_fill;
    nl0   = restart_i ? '0 : cur_i.next_line;
    sc0   = restart_i ? ld_sc : cur_i.aging_score;
    qu0   = restart_i ? '0 : cur_i.quantum_used;

    // Drop finished jobs, keep queue order.
    fin_vec = '1;
    for (int c = 0; c < MAX_JOBS; c++) begin
      fin_vec[c] = (nl0[c] >= len[c]);
    end
    rq1      = rq0;
    qu1      = qu0;
    keep_cnt = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (FILL_W'(i) < fill0) begin
        if (!fin_vec[rq0[i]]) begin
          rq1[keep_cnt[JOB_W-1:0]] = rq0[i];
          keep_cnt = keep_cnt + FILL_W'(1);
        end else if (i == 0) begin
          qu1 = '0;
        end
      end
    end
    fill1 = keep_cnt;

    // Age waiting jobs and look for the first one that beats the head.
    sc2      = sc0;
    rq2      = rq1;
    found    = 1'b0;
    cand_pos = '0;
    ord_cnt  = '0;
    if (cfg_i.policy == POL_AGING && fill1 != '0) begin
      for (int i = 1; i < MAX_JOBS; i++) begin
        if (FILL_W'(i) < fill1 && sc2[rq1[i]] != '0) begin
          sc2[rq1[i]] = sc2[rq1[i]] - LINE_W'(1);
        end
      end
      for (int i = 1; i < MAX_JOBS; i++) begin
        if (!found && FILL_W'(i) < fill1 && sc2[rq1[i]] < sc2[rq1[0]]) begin
          found    = 1'b1;
          cand_pos = JOB_W'(i);
        end
      end
      if (found) begin
        rq2[0]  = rq1[cand_pos];
        ord_cnt = FILL_W'(1);
        for (int t = 1; t < MAX_JOBS; t++) begin
          if (FILL_W'(t) < fill1 && JOB_W'(t) != cand_pos) begin
            rq2[ord_cnt[JOB_W-1:0]] = rq1[t];
            ord_cnt = ord_cnt + FILL_W'(1);
          end
        end
        rq2[ord_cnt[JOB_W-1:0]] = rq1[0];
      end
    end

    // Run one line of the head job.
    head = rq2[0];
    nl2  = nl0;
    if (fill1 != '0) begin
      nl2[head] = nl0[head] + LINE_W'(1);
    end

    // Round robin turn accounting.
    rq3  = rq2;
    qu3  = qu1;
    qsum = qu1 + Q_W'(1);
    qlim = (cfg_i.rr_quantum == '0) ? Q_W'(1) : cfg_i.rr_quantum;
    if (cfg_i.policy == POL_RR && fill1 != '0) begin
      if (qsum >= qlim) begin
        for (int t = 0; t < MAX_JOBS - 1; t++) begin
          if (FILL_W'(t + 1) < fill1) begin
            rq3[t] = rq2[t + 1];
          end
        end
        rq3[fill1[JOB_W-1:0] - JOB_W'(1)] = rq2[0];
        qu3 = '0;
      end else begin
        qu3 = qsum;
      end
    end

    nxt_o.run_queue    = rq3;
    nxt_o.queue_fill   = fill1;
    nxt_o.next_line    = nl2;
    nxt_o.aging_score  = sc2;
    nxt_o.quantum_used = qu3;

    if (fill1 == '0) begin
      res_o.job_id     = '0;
      res_o.line_index = '0;
      res_o.all_done   = 1'b1;
    end else begin
      res_o.job_id     = head;
      res_o.line_index = nl0[head][IDX_W-1:0];
      res_o.all_done   = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/job_scheduler_fcfs_sjf_rr_aging_unit.sv]
// ----------------------------------------------------------------------------
// job_scheduler_fcfs_sjf_rr_aging_unit
// Line-by-line scheduler for a batch of up to three jobs under four policies.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i carries one item per tick: restart = 1 reloads the batch from the
//   configuration registers and schedules its first line, restart = 0
//   advances one line. sched_o returns one item per tick: the job and line
//   that run, or all_done with zero job and line once nothing is left.
//   Policy, job count, the three line counts and the round robin quantum
//   are written over the APB port while no tick is in flight.
//   Path: an accepted item lands in the input register, is scheduled by
//   one pass of compare/select logic over the three queue entries, and
//   its result then loads into the result register.
//   Throughput: one item per cycle while sched_o accepts; the queue and per-job
//   counters update in the same cycle the result register loads.
//   Receiver stall: the result register holds; one more item may sit in the
//   input register, after which tick_i.ready drops until sched_o drains.
//   Reset: configuration returns to FCFS, one job, one line per job, quantum
//   two; the queue is empty, so ticks answer all_done until a restart.
// ----------------------------------------------------------------------------
`default_nettype none

`include "job_scheduler_fcfs_sjf_rr_aging_unit_macros.svh"

module job_scheduler_fcfs_sjf_rr_aging_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jsched_in_if.sink                      tick_i,
  jsched_out_if.source                   sched_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jsched_pkg::PADDR_W-1:0] paddr,
  input  logic [jsched_pkg::DATA_W-1:0]  pwdata,
  output logic [jsched_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);
  import jsched_pkg::*;

  cfg_t         cfg;
  sched_state_t state_q, state_d;
  res_t         res_q, res_d;
  logic         in_vld_q, restart_q;
  logic         out_vld_q;
  logic         adv;

  // Configuration registers.
  jsched_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Scheduling pass between the input register and the result register.
  jsched_step u_step (
    .cfg_i     (cfg),
    .cur_i     (state_q),
    .restart_i (restart_q),
    .nxt_o     (state_d),
    .res_o     (res_d)
  );

  // Advance when an item waits and the result slot is free or draining.
  assign adv          = in_vld_q && (!out_vld_q || sched_o.ready);
  assign tick_i.ready = !in_vld_q || adv;

  // Input register: take a new item when empty or when the current one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.valid && tick_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      restart_q <= tick_i.restart;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (sched_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // Scheduler state: queue in arrival order, empty, counters cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        state_q.run_queue[i] <= JOB_W'(i);
      end
      state_q.queue_fill   <= '0;
      state_q.next_line    <= '0;
      state_q.aging_score  <= '0;
      state_q.quantum_used <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  assign sched_o.valid      = out_vld_q;
  assign sched_o.job_id     = res_q.job_id;
  assign sched_o.line_index = res_q.line_index;
  assign sched_o.all_done   = res_q.all_done;

  `JS_ASSERT_IMPL(a_done_fields_zero, clk_i, rst_ni, out_vld_q && res_q.all_done, (res_q.job_id == '0) && (res_q.line_index == '0), "all_done result carries nonzero job or line")
  `JS_ASSERT_IMPL(a_job_in_range, clk_i, rst_ni, out_vld_q && !res_q.all_done, 32'(res_q.job_id) < MAX_JOBS, "scheduled job id out of range")
  `JS_ASSERT_NEXT(a_empty_gives_done, clk_i, rst_ni, adv && !restart_q && (state_q.queue_fill == '0), out_vld_q && res_q.all_done, "empty queue did not answer all_done")
  `JS_ASSERT_IMPL(a_queue_distinct, clk_i, rst_ni, state_q.queue_fill == FILL_W'(MAX_JOBS), (state_q.run_queue[0] != state_q.run_queue[1]) && (state_q.run_queue[0] != state_q.run_queue[2]) && (state_q.run_queue[1] != state_q.run_queue[2]), "run queue holds a job twice")
  `JS_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_vld_q, tick_i.ready, "input stalled with an empty result register")

endmodule

`default_nettype wire
